// ----- design/etrc_pkg.sv -----
// Shared types and constants for the event trace ring capture block.
package etrc_pkg;

    // Configuration address width and register index field.
    localparam int unsigned ADDR_W = 4;

    // Saturation value for stored thread ids.
    localparam logic [15:0] THREAD_MAX = 16'hFFFF;

    // Reset values of the mutex event codes.
    localparam logic [15:0] WAIT_CODE_RST   = 16'd10;
    localparam logic [15:0] LOCK_CODE_RST   = 16'd11;
    localparam logic [15:0] UNLOCK_CODE_RST = 16'd12;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_code_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_IGNORE = 2'd0,
        REG_WAIT   = 2'd1,
        REG_LOCK   = 2'd2,
        REG_UNLOCK = 2'd3
    } reg_index_t;

    // One input transaction.
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] event_code;
        logic [31:0] thread_id;
        logic [31:0] first_arg;
        logic [31:0] second_arg;
        logic [31:0] timestamp;
        logic [31:0] tick_value;
        logic [15:0] dump_limit;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic        has_entry;
        logic        last;
        logic [31:0] dropped_count;
        logic [31:0] entry_time;
        logic [31:0] entry_tick;
        logic [15:0] entry_event;
        logic [15:0] entry_thread;
        logic [31:0] entry_first_arg;
        logic [31:0] entry_second_arg;
    } out_item_t;

    // One stored ring entry.
    typedef struct packed {
        logic [31:0] time_val;
        logic [31:0] tick_val;
        logic [15:0] event_val;
        logic [15:0] thread_val;
        logic [31:0] first_val;
        logic [31:0] second_val;
    } entry_t;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [31:0] ignore_handle;
        logic [15:0] mutex_wait_code;
        logic [15:0] mutex_lock_code;
        logic [15:0] mutex_unlock_code;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic record_en;
        logic clear_en;
        logic dump_start;
        logic rd_issue;
        logic out_load;
        logic empty_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_zero;
        logic rd_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/etrc_if.sv -----
// Valid/ready channel interfaces for input and result transactions.
interface etrc_in_if
    import etrc_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface etrc_out_if
    import etrc_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- design/etrc_regs.sv -----
// APB-style configuration registers for the filter codes and ignore handle.
module etrc_regs
    import etrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t wr_index;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign wr_index = reg_index_t'(paddr[3:2]);
    assign cfg      = cfg_reg;

    // Register write on the access cycle of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ignore_handle     <= '0;
            cfg_reg.mutex_wait_code   <= WAIT_CODE_RST;
            cfg_reg.mutex_lock_code   <= LOCK_CODE_RST;
            cfg_reg.mutex_unlock_code <= UNLOCK_CODE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_IGNORE: cfg_reg.ignore_handle     <= pwdata;
                REG_WAIT:   cfg_reg.mutex_wait_code   <= pwdata[15:0];
                REG_LOCK:   cfg_reg.mutex_lock_code   <= pwdata[15:0];
                REG_UNLOCK: cfg_reg.mutex_unlock_code <= pwdata[15:0];
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (wr_index)
            REG_IGNORE: prdata = cfg_reg.ignore_handle;
            REG_WAIT:   prdata = {16'd0, cfg_reg.mutex_wait_code};
            REG_LOCK:   prdata = {16'd0, cfg_reg.mutex_lock_code};
            REG_UNLOCK: prdata = {16'd0, cfg_reg.mutex_unlock_code};
        endcase
    end

endmodule

// ----- design/etrc_ctrl.sv -----
// Controller state machine that sequences records, clears and dump reads.
module etrc_ctrl
    import etrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_command,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUMP,
        ST_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rd_valid_reg;
    logic   rd_valid_next;
    logic   move;

    // Next state, command decode and read pipeline bookkeeping.
    always_comb
    begin
        move          = rd_valid_reg && status.out_free;
        cmd           = '0;
        cmd.out_load  = move;
        state_next    = state_reg;
        rd_valid_next = move ? 1'b0 : rd_valid_reg;
        in_ready      = (state_reg == ST_IDLE) && !rd_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (in_command)
                        CMD_RECORD: cmd.record_en = 1'b1;
                        CMD_CLEAR:  cmd.clear_en  = 1'b1;
                        CMD_DUMP:
                        begin
                            if (status.fill_zero)
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = ST_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DUMP:
            begin
                // Issue a read whenever the read stage is free or emptying.
                if (!rd_valid_reg || move)
                begin
                    cmd.rd_issue  = 1'b1;
                    rd_valid_next = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.empty_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and read stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

endmodule

// ----- design/etrc_datapath.sv -----
// Ring memory, pointers, counters, dump read stage and output register.
module etrc_datapath
    import etrc_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  cfg_t       cfg,
    input  in_item_t   in_item,
    input  logic       out_ready,
    output dp_status_t status,
    output logic       out_valid,
    output out_item_t  out_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = PW + 1;

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic [31:0]     drop_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   remain_reg;
    logic [31:0]     dump_drop_reg;
    entry_t          rd_data_reg;
    logic            rd_last_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;

    logic            is_mutex;
    logic            filtered;
    logic            wr_en;
    entry_t          wr_entry;
    logic [PW-1:0]   wr_ptr_inc;
    logic [PW-1:0]   rd_ptr_inc;
    logic [CW-1:0]   dump_count;
    logic [SW-1:0]   start_sum;
    logic [PW-1:0]   start_ptr;

    // Mutex event filter against the ignore handle.
    assign is_mutex = (in_item.event_code == cfg.mutex_wait_code) ||
                      (in_item.event_code == cfg.mutex_lock_code) ||
                      (in_item.event_code == cfg.mutex_unlock_code);
    assign filtered = (cfg.ignore_handle != 32'd0) && is_mutex &&
                      (in_item.first_arg == cfg.ignore_handle);
    assign wr_en    = cmd.record_en && !filtered;

    // Entry to store, thread id saturated to 16 bits.
    always_comb
    begin
        wr_entry.time_val   = in_item.timestamp;
        wr_entry.tick_val   = in_item.tick_value;
        wr_entry.event_val  = in_item.event_code;
        wr_entry.thread_val = (|in_item.thread_id[31:16]) ? THREAD_MAX
                                                           : in_item.thread_id[15:0];
        wr_entry.first_val  = in_item.first_arg;
        wr_entry.second_val = in_item.second_arg;
    end

    // Pointer increments with wrap at the ring depth.
    assign wr_ptr_inc = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // Dump length and start of the oldest entry to emit.
    always_comb
    begin
        if ((in_item.dump_limit != 16'd0) && (16'(fill_reg) > in_item.dump_limit))
        begin
            dump_count = CW'(in_item.dump_limit);
        end
        else
        begin
            dump_count = fill_reg;
        end
        start_sum = SW'(wr_ptr_reg) + SW'(DEPTH) - SW'(dump_count);
        if (start_sum >= SW'(DEPTH))
        begin
            start_ptr = PW'(start_sum - SW'(DEPTH));
        end
        else
        begin
            start_ptr = PW'(start_sum);
        end
    end

    // Ring memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Write pointer, fill count and dropped counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            drop_reg   <= '0;
        end
        else if (cmd.clear_en)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            drop_reg   <= '0;
        end
        else if (wr_en)
        begin
            wr_ptr_reg <= wr_ptr_inc;
            if (fill_reg < CW'(DEPTH))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else
            begin
                drop_reg <= drop_reg + 32'd1;
            end
        end
    end

    // Dump read sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            remain_reg <= '0;
        end
        else if (cmd.dump_start)
        begin
            rd_ptr_reg <= start_ptr;
            remain_reg <= dump_count;
        end
        else if (cmd.rd_issue)
        begin
            rd_ptr_reg <= rd_ptr_inc;
            remain_reg <= remain_reg - 1'b1;
        end
    end

    // Per-dump payload that needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.dump_start)
        begin
            dump_drop_reg <= drop_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_last_reg <= (remain_reg == CW'(1));
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load || cmd.empty_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.has_entry        <= 1'b1;
            out_item_reg.last             <= rd_last_reg;
            out_item_reg.dropped_count    <= dump_drop_reg;
            out_item_reg.entry_time       <= rd_data_reg.time_val;
            out_item_reg.entry_tick       <= rd_data_reg.tick_val;
            out_item_reg.entry_event      <= rd_data_reg.event_val;
            out_item_reg.entry_thread     <= rd_data_reg.thread_val;
            out_item_reg.entry_first_arg  <= rd_data_reg.first_val;
            out_item_reg.entry_second_arg <= rd_data_reg.second_val;
        end
        else if (cmd.empty_load)
        begin
            out_item_reg               <= '0;
            out_item_reg.last          <= 1'b1;
            out_item_reg.dropped_count <= drop_reg;
        end
    end

    assign status.fill_zero = (fill_reg == '0);
    assign status.rd_last   = (remain_reg == CW'(1));
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_item         = out_item_reg;

endmodule

// ----- design/event_trace_ring_capture_unit.sv -----
// Records and clears are accepted one per cycle while no dump is in progress; each takes
// effect in the cycle after acceptance. An empty dump loads its single result into the
// output register once it is free; any other dump reads its entries, oldest first, via
// the registered ring read port, one per cycle while the output is not stalled. Input is
// blocked during a dump. Reset (rst_n, asynchronous, active low) empties the ring, zeroes
// the counters and restores the register defaults at once; no clearing pass is needed.
module event_trace_ring_capture_unit
    import etrc_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)(
    input  logic              clk,
    input  logic              rst_n,
    etrc_in_if.sink           in_ch,
    etrc_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    // Configuration registers.
    etrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller.
    etrc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.payload.command),
        .status     (status),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    assign in_ch.ready = in_ready;

    // Datapath.
    etrc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .in_item   (in_ch.payload),
        .out_ready (out_ch.ready),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_item  (out_ch.payload)
    );

endmodule

// ----- design/etrc_checker.sv -----
// Port-level checks on the event trace ring capture unit, with its bind.
module etrc_checker
    import etrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item,
    input logic      pready
);

    // A stalled result transaction stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    // A result without an entry closes its dump.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.has_entry |-> out_item.last)
        else $error("empty dump result not marked last");

    // A result without an entry carries zero entry fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.has_entry |->
            (out_item.entry_time == 32'd0) && (out_item.entry_event == 16'd0) &&
            (out_item.entry_first_arg == 32'd0))
        else $error("empty dump result carries entry data");

    // The dropped count is the same across all results of one dump.
    a_dump_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last |=>
            !out_valid || (out_item.dropped_count == $past(out_item.dropped_count)))
        else $error("dropped count changed within a dump");

    // The configuration port never waits.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind event_trace_ring_capture_unit etrc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload),
    .pready    (pready)
);

// ----- tb/tb_event_trace_ring_capture_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the event trace ring capture unit.
module tb_event_trace_ring_capture_unit;
    import etrc_pkg::*;

    localparam int unsigned RING_DEPTH    = 64;
    localparam int unsigned PHASE_COUNT   = 5;
    localparam int unsigned PHASE_ITEMS   = 62;
    localparam int unsigned PRESSURE_PH   = 4;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    // One row of the directed table; typed rows carry their single expected result.
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    etrc_in_if  in_ch();
    etrc_out_if out_ch();

    event_trace_ring_capture_unit #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor copy of the registers and the ring.
    logic [31:0] ignore_copy;
    logic [15:0] wait_copy;
    logic [15:0] lock_copy;
    logic [15:0] unlock_copy;
    entry_t      ring_copy [RING_DEPTH];
    int unsigned head_copy;
    int unsigned fill_copy;
    logic [31:0] dropped_copy;

    out_item_t   pending_results [$];
    stim_row_t   directed_rows [$];
    out_item_t   oldest_result;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Works out the dump results an accepted transaction causes and updates the ring copy.
    function automatic void predict_trace(in_item_t it);
        logic        is_mutex;
        int unsigned count;
        int unsigned idx;
        entry_t      ent;
        out_item_t   res;
        case (it.command)
            CMD_RECORD:
            begin
                is_mutex = (it.event_code == wait_copy) || (it.event_code == lock_copy) ||
                           (it.event_code == unlock_copy);
                if (ignore_copy != 0 && is_mutex && it.first_arg == ignore_copy)
                    return;
                ent.time_val   = it.timestamp;
                ent.tick_val   = it.tick_value;
                ent.event_val  = it.event_code;
                ent.thread_val = (it.thread_id > {16'h0, THREAD_MAX}) ? THREAD_MAX :
                                 it.thread_id[15:0];
                ent.first_val  = it.first_arg;
                ent.second_val = it.second_arg;
                ring_copy[head_copy] = ent;
                head_copy = (head_copy + 1) % RING_DEPTH;
                if (fill_copy < RING_DEPTH)
                    fill_copy++;
                else
                    dropped_copy++;
            end
            CMD_DUMP:
            begin
                res = '0;
                res.dropped_count = dropped_copy;
                if (fill_copy == 0)
                begin
                    res.last = 1'b1;
                    pending_results.push_back(res);
                    return;
                end
                count = fill_copy;
                if (it.dump_limit != 0 && count > it.dump_limit)
                    count = it.dump_limit;
                // Oldest of the selected entries goes first.
                for (int unsigned i = 0; i < count; i++)
                begin
                    idx = (head_copy + RING_DEPTH - count + i) % RING_DEPTH;
                    res.has_entry        = 1'b1;
                    res.last             = (i + 1 == count);
                    res.entry_time       = ring_copy[idx].time_val;
                    res.entry_tick       = ring_copy[idx].tick_val;
                    res.entry_event      = ring_copy[idx].event_val;
                    res.entry_thread     = ring_copy[idx].thread_val;
                    res.entry_first_arg  = ring_copy[idx].first_val;
                    res.entry_second_arg = ring_copy[idx].second_val;
                    pending_results.push_back(res);
                end
            end
            CMD_CLEAR:
            begin
                head_copy    = 0;
                fill_copy    = 0;
                dropped_copy = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic in_item_t trace_item(logic [1:0] cmd, logic [15:0] code,
                                            logic [31:0] tid, logic [31:0] a0,
                                            logic [31:0] a1, logic [31:0] ts,
                                            logic [31:0] tick, logic [15:0] lim);
        in_item_t it;
        it.command    = cmd;
        it.event_code = code;
        it.thread_id  = tid;
        it.first_arg  = a0;
        it.second_arg = a1;
        it.timestamp  = ts;
        it.tick_value = tick;
        it.dump_limit = lim;
        return it;
    endfunction

    function automatic out_item_t empty_dump_result();
        out_item_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(in_item_t it, logic typed, out_item_t res);
        stim_row_t row;
        row.item   = it;
        row.typed  = typed;
        row.result = res;
        directed_rows.push_back(row);
    endfunction

    // Random transaction: mostly records aimed at the filter and the saturation edge.
    function automatic in_item_t random_trace_item(bit allow_clear);
        in_item_t    it;
        int unsigned pick;
        it.second_arg = $urandom;
        it.timestamp  = $urandom;
        it.tick_value = $urandom;
        pick = $urandom_range(99);
        if (allow_clear && pick < 4)
            it.command = CMD_CLEAR;
        else if (pick < 6)
            it.command = CMD_UNUSED;
        else if (pick < 20)
            it.command = CMD_DUMP;
        else
            it.command = CMD_RECORD;
        case ($urandom_range(5))
            0: it.event_code = wait_copy;
            1: it.event_code = lock_copy;
            2: it.event_code = unlock_copy;
            default: it.event_code = 16'($urandom);
        endcase
        it.first_arg = $urandom_range(1) ? ignore_copy : $urandom;
        case ($urandom_range(3))
            0: it.thread_id = $urandom_range(32'h0000_FFFF);
            1: it.thread_id = $urandom_range(1) ? 32'h0000_FFFF : 32'h0001_0000;
            default: it.thread_id = $urandom;
        endcase
        case ($urandom_range(5))
            0, 1: it.dump_limit = '0;
            2, 3: it.dump_limit = 16'($urandom_range(8, 1));
            4: it.dump_limit = 16'($urandom_range(70, 60));
            default: it.dump_limit = 16'($urandom);
        endcase
        return it;
    endfunction

    function automatic string format_result(out_item_t r);
        return $sformatf({"has_entry=%0d last=%0d dropped=%h time=%h tick=%h ",
                          "event=%h thread=%h arg0=%h arg1=%h"},
                         r.has_entry, r.last, r.dropped_count, r.entry_time, r.entry_tick,
                         r.entry_event, r.entry_thread, r.entry_first_arg, r.entry_second_arg);
    endfunction

    // APB write: setup cycle, then access cycle; the predictor follows the register.
    task automatic write_register(reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IGNORE: ignore_copy = value;
            REG_WAIT:   wait_copy   = value[15:0];
            REG_LOCK:   lock_copy   = value[15:0];
            REG_UNLOCK: unlock_copy = value[15:0];
        endcase
        @(posedge clk);
    endtask

    // Offers one transaction after an optional idle gap and records what it should produce.
    task automatic apply_item(in_item_t it, logic typed, out_item_t typed_res);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        if (typed)
            pending_results.push_back(typed_res);
        else
            predict_trace(it);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: %s", format_result(out_ch.payload));
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_ch.payload !== oldest_result)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected %s", format_result(oldest_result));
                        $display("  actual   %s", format_result(out_ch.payload));
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        out_item_t   ones_entry;
        logic [31:0] ign_val;
        logic [15:0] wait_val;
        logic [15:0] lock_val;
        logic [15:0] unlock_val;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        ignore_copy    = '0;
        wait_copy      = WAIT_CODE_RST;
        lock_copy      = LOCK_CODE_RST;
        unlock_copy    = UNLOCK_CODE_RST;
        head_copy      = 0;
        fill_copy      = 0;
        dropped_copy   = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the filter armed on one handle and default codes.
        write_register(REG_IGNORE, 32'h0000_0BAD);

        ones_entry                  = '1;
        ones_entry.dropped_count    = '0;

        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd0), 1'b1,
                empty_dump_result());
        add_row(trace_item(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'hFFFF), 1'b1,
                empty_dump_result());
        add_row(trace_item(CMD_RECORD, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(trace_item(CMD_RECORD, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd1), 1'b1, ones_entry);
        // Mutex events on the ignored handle are dropped; others are kept.
        add_row(trace_item(CMD_RECORD, 16'd10, 32'd5, 32'h0BAD, 32'h1, 32'h100, 32'h10, '0),
                1'b0, '0);
        add_row(trace_item(CMD_RECORD, 16'd11, 32'd6, 32'h0BAD, 32'h2, 32'h101, 32'h11, '0),
                1'b0, '0);
        add_row(trace_item(CMD_RECORD, 16'd12, 32'd7, 32'h0BAD, 32'h3, 32'h102, 32'h12, '0),
                1'b0, '0);
        add_row(trace_item(CMD_RECORD, 16'd13, 32'h0001_0000, 32'h0BAD, 32'h4, 32'h103,
                           32'h13, '0), 1'b0, '0);
        add_row(trace_item(CMD_RECORD, 16'd10, 32'h0000_FFFF, 32'h0BAC, 32'h5, 32'h104,
                           32'h14, '0), 1'b0, '0);
        add_row(trace_item(CMD_RECORD, 16'd11, 32'h0000_FFFE, 32'h0, 32'h6, 32'h105,
                           32'h15, '0), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd0), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd3), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'hFFFF), 1'b0, '0);
        add_row(trace_item(CMD_UNUSED, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(trace_item(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd0), 1'b1,
                empty_dump_result());
        add_row(trace_item(CMD_RECORD, 16'hA5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                           32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hA5A5), 1'b0, '0);
        add_row(trace_item(CMD_RECORD, 16'h5A5A, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                           32'h5A5A_5A5A, 32'hA5A5_A5A5, 16'h5A5A), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd2), 1'b0, '0);
        add_row(trace_item(CMD_CLEAR, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd5), 1'b1,
                empty_dump_result());

        foreach (directed_rows[i])
            apply_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        drain_results();

        // Random phases, each with its own register setting and an idling pattern.
        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    ign_val = '0; wait_val = WAIT_CODE_RST; lock_val = LOCK_CODE_RST;
                    unlock_val = UNLOCK_CODE_RST;
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1:
                begin
                    ign_val = '1; wait_val = '0; lock_val = '1; unlock_val = 16'h1234;
                    send_idle_pct = 70; recv_stall_pct = 0;
                end
                2:
                begin
                    ign_val = 32'd1; wait_val = 16'd7; lock_val = 16'd7; unlock_val = 16'd7;
                    send_idle_pct = 0; recv_stall_pct = 70;
                end
                3:
                begin
                    ign_val = $urandom | 32'd1; wait_val = 16'($urandom);
                    lock_val = 16'($urandom); unlock_val = 16'($urandom);
                    send_idle_pct = 32; recv_stall_pct = 32;
                end
                default:
                begin
                    ign_val = 32'h0000_0BAD; wait_val = WAIT_CODE_RST;
                    lock_val = LOCK_CODE_RST; unlock_val = UNLOCK_CODE_RST;
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
            endcase
            write_register(REG_IGNORE, ign_val);
            write_register(REG_WAIT, {16'h0, wait_val});
            write_register(REG_LOCK, {16'h0, lock_val});
            write_register(REG_UNLOCK, {16'h0, unlock_val});

            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == PRESSURE_PH && n == 10)
                begin
                    // Long receiver hold-off while a full dump and more transactions pile up.
                    hold_left = HOLD_CYCLES;
                    apply_item(trace_item(CMD_DUMP, '0, '0, '0, '0, '0, '0, 16'd0), 1'b0, '0);
                end
                if (phase == PRESSURE_PH && n == 40)
                    drain_results();
                apply_item(random_trace_item(phase >= 2), 1'b0, '0);
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
